FILE: hdl/kpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key press classifier with tick timers.
// Depends on nothing; kpc_key_scan, kpc_timers and the top level use it by scoped names.
package kpc_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Latched key events.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SCAN_DIVIDE     = 3'd0;
   localparam logic [2:0] CSR_LONG_THRESHOLD  = 3'd1;
   localparam logic [2:0] CSR_GAP_LIMIT       = 3'd2;
   localparam logic [2:0] CSR_GAP_UNIT_MS     = 3'd3;
   localparam logic [2:0] CSR_SHUTDOWN_PRESET = 3'd4;

   // Configuration reset values.
   localparam logic [3:0]  SCAN_DIVIDE_RST     = 4'd3;
   localparam logic [9:0]  LONG_THRESHOLD_RST  = 10'd25;
   localparam logic [7:0]  GAP_LIMIT_RST       = 8'd10;
   localparam logic [7:0]  GAP_UNIT_MS_RST     = 8'd20;
   localparam logic [31:0] SHUTDOWN_PRESET_RST = 32'd0;

   // The power-off timer and the number of timers shown in the zero mask.
   localparam int SHUTDOWN_TIMER = 2;
   localparam int ZERO_BITS      = 6;

   // Saturation limits.
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [7:0]  RUN_MAX   = 8'hFF;

   // One decoded item as seen by the state units.
   typedef struct packed {
      logic        tick;
      logic        load;
      logic        clear;
      logic        key_level;
      logic [2:0]  timer_index;
      logic [31:0] load_value;
   } step_cmd_type;

   // Key scan configuration.
   typedef struct packed {
      logic [3:0] scan_divide;
      logic [9:0] long_threshold;
      logic [7:0] gap_limit;
   } scan_cfg_type;

   // Key scan state after the current item.
   typedef struct packed {
      logic [1:0]  key_event;
      logic [15:0] idle_count;
      logic [7:0]  press_run;
      logic        key_down;
   } scan_stat_type;

endpackage

FILE: hdl/kpc_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one item.
// Depends on nothing.
interface kpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        key_level;
   logic [2:0]  timer_index;
   logic [31:0] load_value;

   modport source (output valid, kind, key_level, timer_index, load_value, input ready);
   modport sink (input valid, kind, key_level, timer_index, load_value, output ready);
endinterface

FILE: hdl/kpc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result item.
// Depends on nothing.
interface kpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  key_event;
   logic [23:0] gap_ms;
   logic [7:0]  press_run;
   logic        key_down;
   logic [31:0] tick_count;
   logic [5:0]  timers_zero;
   logic [31:0] timer_value;

   modport source (output valid, key_event, gap_ms, press_run, key_down, tick_count,
                   timers_zero, timer_value, input ready);
   modport sink (input valid, key_event, gap_ms, press_run, key_down, tick_count,
                 timers_zero, timer_value, output ready);
endinterface

FILE: hdl/kpc_csr_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on nothing.
interface kpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/kpc_key_scan.sv
`timescale 1ns / 1ps
// Key scan state: scan divider, held and idle counters, quick-press run, event latch.
// Depends on kpc_pkg.
module kpc_key_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  kpc_pkg::step_cmd_type  cmd,
   input  kpc_pkg::scan_cfg_type  cfg,
   output kpc_pkg::scan_stat_type stat
);

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [15:0] idle_ff, idle_in;
   logic [7:0]  quick_ff, quick_in;
   logic [1:0]  event_ff, event_in;
   logic        level_ff, level_in;

   logic [4:0]  divide;
   logic [4:0]  phase_inc;
   logic [15:0] held_a;
   logic [15:0] idle_a;
   logic [15:0] idle_b;
   logic [15:0] threshold;
   logic [15:0] gap;

   // Next state for one item.
   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      idle_in   = idle_ff;
      quick_in  = quick_ff;
      event_in  = event_ff;
      level_in  = level_ff;
      divide    = (cfg.scan_divide == 4'd0) ? 5'd1 : {1'b0, cfg.scan_divide};
      phase_inc = {1'b0, phase_ff} + 5'd1;
      threshold = {6'd0, cfg.long_threshold};
      gap       = {8'd0, cfg.gap_limit};
      held_a    = held_ff;
      idle_a    = idle_ff;
      idle_b    = idle_ff;

      if (cmd.tick) begin
         level_in = cmd.key_level;
         if (phase_inc >= divide) begin
            phase_in = 4'd0;
            // Key scan: a press restarts the gap and counts the hold.
            if (cmd.key_level) begin
               idle_a = 16'd0;
               if (held_ff != kpc_pkg::COUNT_MAX) begin
                  held_a = held_ff + 16'd1;
               end
            end
            if (held_a >= threshold) begin
               event_in = kpc_pkg::EV_LONG;
            end
            if (!cmd.key_level) begin
               // A release after a short hold is a short press.
               if (held_a < threshold && held_a != 16'd0) begin
                  event_in = kpc_pkg::EV_SHORT;
                  if (idle_a < gap && quick_ff != kpc_pkg::RUN_MAX) begin
                     quick_in = quick_ff + 8'd1;
                  end
               end
               idle_b = (idle_a != kpc_pkg::COUNT_MAX) ? idle_a + 16'd1 : idle_a;
               if (idle_b >= gap) begin
                  quick_in = 8'd0;
               end
               held_a = 16'd0;
            end
            held_in = held_a;
            idle_in = cmd.key_level ? idle_a : idle_b;
         end else begin
            phase_in = phase_inc[3:0];
         end
      end else if (cmd.clear) begin
         event_in = kpc_pkg::EV_NONE;
      end
   end

   assign stat.key_event  = event_in;
   assign stat.idle_count = idle_in;
   assign stat.press_run  = quick_in;
   assign stat.key_down   = level_in;

   // State registers, updated when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 4'd0;
         held_ff  <= 16'd0;
         idle_ff  <= 16'd0;
         quick_ff <= 8'd0;
         event_ff <= kpc_pkg::EV_NONE;
         level_ff <= 1'b0;
      end else if (enable) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         idle_ff  <= idle_in;
         quick_ff <= quick_in;
         event_ff <= event_in;
         level_ff <= level_in;
      end
   end

endmodule

FILE: hdl/kpc_timers.sv
`timescale 1ns / 1ps
// Bank of down-timers: decrement on ticks, load by index, zero mask and readback.
// Depends on kpc_pkg.
module kpc_timers #(
   parameter int NUM_TIMERS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  kpc_pkg::step_cmd_type cmd,
   output logic [5:0]            timers_zero,
   output logic [31:0]           timer_value
);

   localparam int SHOWN = (NUM_TIMERS < kpc_pkg::ZERO_BITS) ? NUM_TIMERS : kpc_pkg::ZERO_BITS;

   logic [31:0] tmr_ff [NUM_TIMERS];
   logic [31:0] tmr_in [NUM_TIMERS];

   // Next timer values: count down while nonzero, or take a load.
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         tmr_in[i] = tmr_ff[i];
         if (cmd.tick && tmr_ff[i] != 32'd0) begin
            tmr_in[i] = tmr_ff[i] - 32'd1;
         end
         if (cmd.load && int'(cmd.timer_index) == i) begin
            tmr_in[i] = cmd.load_value;
         end
      end
   end

   // Zero mask and addressed readback; missing timers read as zero.
   always_comb begin
      timers_zero = 6'd0;
      timer_value = 32'd0;
      for (int i = 0; i < SHOWN; i++) begin
         timers_zero[i] = (tmr_in[i] == 32'd0);
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (int'(cmd.timer_index) == i) begin
            timer_value = tmr_in[i];
         end
      end
   end

   // The power-off timer takes its preset at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_ff[i] <= (i == kpc_pkg::SHUTDOWN_TIMER) ? kpc_pkg::SHUTDOWN_PRESET_RST : 32'd0;
         end
      end else if (enable) begin
         tmr_ff <= tmr_in;
      end
   end

endmodule

FILE: hdl/key_press_classifier_tick_timers.sv
`timescale 1ns / 1ps
// Top level of the key press classifier with tick timers.
// Depends on kpc_pkg, kpc_req_if, kpc_rsp_if, kpc_csr_if, kpc_key_scan, kpc_timers.
//
// Usage:
//   req_if carries one item per transfer: a tick with the sampled key level,
//   a load of one down-timer, or a clear of the latched key event.
//   rsp_if returns exactly one result per item, in order: the latched event,
//   the idle gap in milliseconds, the quick-press run, the mirrored key level,
//   the tick count, the timer zero mask and the addressed timer's value.
//   csr_if writes the configuration registers by index; it is always ready.
//   Write it only while no item is in flight.
// Timing:
//   An item is captured in an input register and then processed into the
//   result register, waiting while a result is held. One item per cycle is
//   sustained while rsp_if.ready stays high; the state counters and timer bank
//   update as the item moves from the input register to the result register.
// Reset (synchronous) clears all counters, the event latch and the timers and
//   restores the register defaults. When rsp_if.ready is low the result holds,
//   one more item waits in the input register, and then req_if.ready drops.
//   The shutdown preset is applied at reset, where it holds its reset value.
module key_press_classifier_tick_timers #(
   parameter int NUM_TIMERS = 6
) (
   input logic       clock,
   input logic       reset,
   kpc_req_if.sink   req_if,
   kpc_rsp_if.source rsp_if,
   kpc_csr_if.sink   csr_if
);

   // Configuration registers.
   logic [3:0] scan_divide_ff;
   logic [9:0] long_threshold_ff;
   logic [7:0] gap_limit_ff;
   logic [7:0] gap_unit_ff;

   // Input register.
   logic        in_vld_ff;
   logic [1:0]  kind_ff;
   logic        level_ff;
   logic [2:0]  index_ff;
   logic [31:0] load_ff;

   // Result register.
   logic        out_vld_ff;
   logic [1:0]  event_ff;
   logic [23:0] gap_ms_ff;
   logic [7:0]  run_ff;
   logic        down_ff;
   logic [31:0] ticks_out_ff;
   logic [5:0]  zero_ff;
   logic [31:0] value_ff;

   logic [31:0] ticks_ff, ticks_in;

   logic                   advance;
   logic                   req_take;
   kpc_pkg::step_cmd_type  cmd;
   kpc_pkg::scan_cfg_type  scan_cfg;
   kpc_pkg::scan_stat_type stat;
   logic [5:0]             zero_mask;
   logic [31:0]            timer_value;
   logic [23:0]            gap_ms;

   // Handshakes.
   assign advance       = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready  = !in_vld_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   // Configuration writes; the shutdown preset has no effect outside reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_divide_ff    <= kpc_pkg::SCAN_DIVIDE_RST;
         long_threshold_ff <= kpc_pkg::LONG_THRESHOLD_RST;
         gap_limit_ff      <= kpc_pkg::GAP_LIMIT_RST;
         gap_unit_ff       <= kpc_pkg::GAP_UNIT_MS_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            kpc_pkg::CSR_SCAN_DIVIDE:    scan_divide_ff    <= csr_if.data[3:0];
            kpc_pkg::CSR_LONG_THRESHOLD: long_threshold_ff <= csr_if.data[9:0];
            kpc_pkg::CSR_GAP_LIMIT:      gap_limit_ff      <= csr_if.data[7:0];
            kpc_pkg::CSR_GAP_UNIT_MS:    gap_unit_ff       <= csr_if.data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: takes a new item whenever it is empty or the current one moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
      if (req_take) begin
         kind_ff  <= req_if.kind;
         level_ff <= req_if.key_level;
         index_ff <= req_if.timer_index;
         load_ff  <= req_if.load_value;
      end
   end

   // Item decode.
   assign cmd.tick        = (kind_ff == kpc_pkg::KIND_TICK);
   assign cmd.load        = (kind_ff == kpc_pkg::KIND_LOAD);
   assign cmd.clear       = (kind_ff == kpc_pkg::KIND_CLEAR);
   assign cmd.key_level   = level_ff;
   assign cmd.timer_index = index_ff;
   assign cmd.load_value  = load_ff;

   assign scan_cfg.scan_divide    = scan_divide_ff;
   assign scan_cfg.long_threshold = long_threshold_ff;
   assign scan_cfg.gap_limit      = gap_limit_ff;

   kpc_key_scan u_key_scan (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cmd    (cmd),
      .cfg    (scan_cfg),
      .stat   (stat)
   );

   kpc_timers #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_timers (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .cmd         (cmd),
      .timers_zero (zero_mask),
      .timer_value (timer_value)
   );

   // Counter of tick items, wraps.
   assign ticks_in = cmd.tick ? ticks_ff + 32'd1 : ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= 32'd0;
      end else if (advance) begin
         ticks_ff <= ticks_in;
      end
   end

   // Gap in milliseconds: 16-bit idle count times 8-bit unit.
   assign gap_ms = {8'd0, stat.idle_count} * {16'd0, gap_unit_ff};

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) begin
         event_ff     <= stat.key_event;
         gap_ms_ff    <= gap_ms;
         run_ff       <= stat.press_run;
         down_ff      <= stat.key_down;
         ticks_out_ff <= ticks_in;
         zero_ff      <= zero_mask;
         value_ff     <= timer_value;
      end
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.key_event   = event_ff;
   assign rsp_if.gap_ms      = gap_ms_ff;
   assign rsp_if.press_run   = run_ff;
   assign rsp_if.key_down    = down_ff;
   assign rsp_if.tick_count  = ticks_out_ff;
   assign rsp_if.timers_zero = zero_ff;
   assign rsp_if.timer_value = value_ff;

endmodule
